// ===== rtl/easp_pkg.sv =====
// shared types, codes and character helpers for the edit stream parser
package easp_pkg;

  localparam int PS_W   = 6;
  localparam int LINE_W = 16;
  localparam int KIND_W = 3;
  localparam int BYTE_W = 8;
  localparam int PH_W   = 3;

  localparam logic [PH_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PH_W-1:0] PH_NAME    = 3'd1;
  localparam logic [PH_W-1:0] PH_NAME_SP = 3'd2;
  localparam logic [PH_W-1:0] PH_VAL     = 3'd3;
  localparam logic [PH_W-1:0] PH_VAL_SP  = 3'd4;

  localparam logic [KIND_W-1:0] K_NAME  = 3'd0;
  localparam logic [KIND_W-1:0] K_VALUE = 3'd1;
  localparam logic [KIND_W-1:0] K_SET   = 3'd2;
  localparam logic [KIND_W-1:0] K_DEL   = 3'd3;
  localparam logic [KIND_W-1:0] K_ERR   = 3'd4;

  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3d;
  localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5f;

  localparam logic [LINE_W-1:0] LINE_MAX = 16'hffff;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // one step's worth of results: [close] [held spaces] [main token]
  typedef struct packed {
    logic              has_close;
    logic [KIND_W-1:0] close_kind;
    logic [PS_W-1:0]   nsp;
    logic              has_main;
    logic [KIND_W-1:0] main_kind;
    logic [BYTE_W-1:0] main_byte;
    logic [LINE_W-1:0] line;
  } cmd_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] c);
    return (c == CH_SP) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
    return (c == CH_UNDER) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

// ===== rtl/easp_if.sv =====
// valid/ready channel interfaces for the text input and the token output
interface easp_in_if import easp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface easp_out_if import easp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [BYTE_W-1:0] token_byte;
  logic [LINE_W-1:0] error_line;
  logic              last_of_run;
  modport source (output valid, token_kind, token_byte, error_line, last_of_run, input ready);
  modport sink   (input valid, token_kind, token_byte, error_line, last_of_run, output ready);
endinterface

// ===== rtl/env_assignment_stream_parser_top.sv =====
// a byte's command goes into the command queue, its tokens into the output register
// throughput, while the sink is ready: one byte per cycle while each byte gives at most
//   one token; a byte gives 1 + held spaces tokens (up to 33), or 2 when a close meets
//   a new name, one token per cycle from the emitter, a 4-entry queue absorbing bursts
// reset: synchronous active-low rst_n returns parse state, line count, queue and
//   output register to their idle values; no clearing pass
module env_assignment_stream_parser_top import easp_pkg::*; #(
  parameter int PENDING_MAX = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  easp_in_if.sink    in_ch,
  easp_out_if.source out_ch
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_wdata, q_rdata;

  easp_front #(.PENDING_MAX(PENDING_MAX)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  easp_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  easp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/easp_front.sv =====
// front end: accepts text bytes, runs the parse state and issues token commands
module easp_front import easp_pkg::*; #(
  parameter int PENDING_MAX = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  easp_in_if.sink   in_ch,
  input  logic      q_full,
  output logic      q_push,
  output cmd_t      q_data
);

  localparam logic [PS_W-1:0] PMAX = PS_W'(PENDING_MAX);

  logic [PH_W-1:0]   ph_r, ph_nxt;
  logic              cmt_r, cmt_nxt;
  logic              als_r, als_nxt;
  logic              vs_r, vs_nxt;
  logic [PS_W-1:0]   ps_r, ps_nxt;
  logic [LINE_W-1:0] lc_r, lc_nxt;
  logic              halt_r, halt_nxt;
  cmd_t              cmd;
  logic              accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign q_data      = cmd;
  assign q_push      = accept && (cmd.has_close || cmd.has_main);

  always_comb begin
    logic [BYTE_W-1:0] c;
    logic              skip;
    logic              do_mid;
    logic              do_start;
    logic              do_close;
    logic              do_fail;
    c        = in_ch.text_byte;
    skip     = 1'b0;
    do_mid   = 1'b0;
    do_start = 1'b0;
    do_close = 1'b0;
    do_fail  = 1'b0;
    ph_nxt   = ph_r;
    cmt_nxt  = cmt_r;
    als_nxt  = als_r;
    vs_nxt   = vs_r;
    ps_nxt   = ps_r;
    lc_nxt   = lc_r;
    halt_nxt = halt_r;
    cmd      = '0;

    if (!halt_r) begin
      if (in_ch.end_of_text) begin
        unique case (ph_r)
          PH_NAME, PH_NAME_SP: do_fail = 1'b1;
          PH_VAL, PH_VAL_SP:   do_close = 1'b1;
          default: ;
        endcase
      end else begin
        if (c == CH_HASH) cmt_nxt = 1'b1;
        if (c == CH_NL && lc_r != LINE_MAX) lc_nxt = lc_r + LINE_W'(1);
        if (cmt_nxt) begin
          if (c != CH_NL) begin
            skip = 1'b1;
          end else begin
            cmt_nxt = 1'b0;
            als_nxt = 1'b0;
          end
        end
        if (!skip) begin
          if (c == CH_NL) begin
            // blank line
            if (als_nxt) begin
              unique case (ph_r)
                PH_NAME, PH_NAME_SP: do_fail = 1'b1;
                PH_VAL, PH_VAL_SP:   do_close = 1'b1;
                default: ;
              endcase
            end
            als_nxt = 1'b1;
          end else begin
            if (als_nxt) begin
              unique case (ph_r)
                PH_NAME: begin
                  if (!is_ws(c)) do_fail = 1'b1;
                  else ph_nxt = PH_NAME_SP;
                end
                PH_NAME_SP: do_mid = 1'b1;
                PH_VAL, PH_VAL_SP: begin
                  // continuation line joins with exactly one space
                  if (ph_r == PH_VAL) begin
                    ps_nxt = PS_W'(1);
                    ph_nxt = PH_VAL_SP;
                  end
                  if (!is_ws(c)) begin
                    do_close = 1'b1;
                    do_start = 1'b1;
                  end
                end
                default: do_start = 1'b1;
              endcase
            end else begin
              do_mid = 1'b1;
            end
            als_nxt = 1'b0;
          end
        end
      end

      if (do_mid) begin
        unique case (ph_r)
          PH_NAME: begin
            if (is_ws(c)) ph_nxt = PH_NAME_SP;
            else if (c == CH_EQ) ph_nxt = PH_VAL_SP;
            else if (!is_alnum(c)) do_fail = 1'b1;
            else begin
              cmd.has_main  = 1'b1;
              cmd.main_kind = K_NAME;
              cmd.main_byte = c;
            end
          end
          PH_NAME_SP: begin
            if (c == CH_EQ) ph_nxt = PH_VAL_SP;
            else if (!is_ws(c)) do_fail = 1'b1;
          end
          PH_VAL, PH_VAL_SP: begin
            if (is_ws(c)) begin
              if (ph_r == PH_VAL && ps_r < PMAX) ps_nxt = ps_r + PS_W'(1);
            end else begin
              cmd.nsp       = ps_r;
              cmd.has_main  = 1'b1;
              cmd.main_kind = K_VALUE;
              cmd.main_byte = c;
              ps_nxt        = '0;
              vs_nxt        = 1'b1;
              ph_nxt        = PH_VAL;
            end
          end
          default: do_fail = 1'b1;
        endcase
      end

      if (do_close) begin
        cmd.has_close  = 1'b1;
        cmd.close_kind = vs_r ? K_SET : K_DEL;
        vs_nxt         = 1'b0;
        ps_nxt         = '0;
        ph_nxt         = PH_IDLE;
      end

      if (do_start) begin
        if (!is_alpha(c)) begin
          do_fail = 1'b1;
        end else begin
          cmd.has_main  = 1'b1;
          cmd.main_kind = K_NAME;
          cmd.main_byte = c;
          ph_nxt        = PH_NAME;
        end
      end

      if (do_fail) begin
        cmd.has_main  = 1'b1;
        cmd.main_kind = K_ERR;
        cmd.main_byte = '0;
        halt_nxt      = 1'b1;
      end

      if (in_ch.end_of_text && !do_fail) begin
        ph_nxt  = PH_IDLE;
        cmt_nxt = 1'b0;
        als_nxt = 1'b1;
        vs_nxt  = 1'b0;
        ps_nxt  = '0;
        lc_nxt  = LINE_W'(1);
      end
    end
    cmd.line = in_ch.end_of_text ? lc_r : lc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      cmt_r  <= 1'b0;
      als_r  <= 1'b1;
      vs_r   <= 1'b0;
      ps_r   <= '0;
      lc_r   <= LINE_W'(1);
      halt_r <= 1'b0;
    end else if (accept) begin
      ph_r   <= ph_nxt;
      cmt_r  <= cmt_nxt;
      als_r  <= als_nxt;
      vs_r   <= vs_nxt;
      ps_r   <= ps_nxt;
      lc_r   <= lc_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// ===== rtl/easp_cmd_fifo.sv =====
// short command queue between the parse front end and the token emitter
module easp_cmd_fifo import easp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t rdata,
  output logic full,
  output logic empty
);

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QAW'(1);
      if (pop) rp_r <= rp_r + QAW'(1);
      if (push && !pop) cnt_r <= cnt_r + (QAW+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (QAW+1)'(1);
    end
  end

endmodule

// ===== rtl/easp_back.sv =====
// back end: expands commands into registered tokens, one per cycle unless stalled
module easp_back import easp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_data,
  output logic      q_pop,
  easp_out_if.source out_ch
);

  logic              busy_r, busy_nxt;
  cmd_t              cur_r, cur_nxt;
  logic              cl_r, cl_nxt;
  logic [PS_W-1:0]   sp_r, sp_nxt;
  logic              ov_r;
  logic [KIND_W-1:0] okind_r;
  logic [BYTE_W-1:0] obyte_r;
  logic [LINE_W-1:0] oline_r;
  logic              olast_r;

  cmd_t              sel;
  logic              sel_cl;
  logic [PS_W-1:0]   sel_sp;
  logic              out_free;
  logic              fire;
  logic [KIND_W-1:0] tkind;
  logic [BYTE_W-1:0] tbyte;
  logic              tlast;

  assign out_free = !ov_r || out_ch.ready;
  assign sel      = busy_r ? cur_r : q_data;
  assign sel_cl   = busy_r ? cl_r : q_data.has_close;
  assign sel_sp   = busy_r ? sp_r : q_data.nsp;
  assign fire     = out_free && (busy_r || !q_empty);
  assign q_pop    = fire && !busy_r;

  always_comb begin
    cl_nxt = sel_cl;
    sp_nxt = sel_sp;
    if (sel_cl) begin
      tkind  = sel.close_kind;
      tbyte  = '0;
      tlast  = !sel.has_main;
      cl_nxt = 1'b0;
    end else if (sel_sp != '0) begin
      tkind  = K_VALUE;
      tbyte  = CH_SP;
      tlast  = 1'b0;
      sp_nxt = sel_sp - PS_W'(1);
    end else begin
      tkind = sel.main_kind;
      tbyte = sel.main_byte;
      tlast = 1'b1;
    end
    cur_nxt  = sel;
    busy_nxt = busy_r;
    if (fire) busy_nxt = !tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (fire) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur_r   <= cur_nxt;
      cl_r    <= cl_nxt;
      sp_r    <= sp_nxt;
      okind_r <= tkind;
      obyte_r <= tbyte;
      oline_r <= sel.line;
      olast_r <= tlast;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.token_kind  = okind_r;
  assign out_ch.token_byte  = obyte_r;
  assign out_ch.error_line  = oline_r;
  assign out_ch.last_of_run = olast_r;

endmodule

// ===== tb/easp_token_checker.sv =====
// token checker: predicts the parser's tokens from accepted text bytes and compares them
`timescale 1ns / 100ps
module easp_token_checker import easp_pkg::*; #(
  parameter int PENDING_MAX = 32
) (
  input  logic clk,
  input  logic rst_n,
  easp_in_if   in_ch,
  easp_out_if  out_ch,
  output int   n_fail,
  output int   n_pending
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] ch;
    logic [LINE_W-1:0] line;
    logic              last;
  } token_t;

  token_t            tokens_due[$];
  logic [PH_W-1:0]   phase;
  logic              in_remark;
  logic              at_bol;
  logic              has_value;
  logic              stopped;
  logic              err_hit;
  logic [PS_W-1:0]   held_sp;
  logic [LINE_W-1:0] line_no;
  int                n_step;

  function automatic logic space_char(input logic [BYTE_W-1:0] c);
    return (c == CH_SP) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic letter_char(input logic [BYTE_W-1:0] c);
    return (c == CH_UNDER) || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic word_char(input logic [BYTE_W-1:0] c);
    return letter_char(c) || ((c >= "0") && (c <= "9"));
  endfunction

  function automatic void clear_state();
    phase     = PH_IDLE;
    in_remark = 1'b0;
    at_bol    = 1'b1;
    has_value = 1'b0;
    held_sp   = '0;
    line_no   = 16'd1;
  endfunction

  function automatic void emit(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] ch);
    token_t t;
    t.kind = kind;
    t.ch   = ch;
    t.line = line_no;
    t.last = 1'b0;
    tokens_due.push_back(t);
    n_step++;
  endfunction

  function automatic void halt_now();
    emit(K_ERR, '0);
    stopped = 1'b1;
    err_hit = 1'b1;
  endfunction

  function automatic void close_edit();
    emit(has_value ? K_SET : K_DEL, '0);
    has_value = 1'b0;
    held_sp   = '0;
    phase     = PH_IDLE;
  endfunction

  // held spaces go out just before the next real value byte
  function automatic void value_char(input logic [BYTE_W-1:0] c);
    for (int i = 0; i < int'(held_sp); i++) emit(K_VALUE, CH_SP);
    held_sp = '0;
    emit(K_VALUE, c);
    has_value = 1'b1;
    phase     = PH_VAL;
  endfunction

  function automatic void start_name(input logic [BYTE_W-1:0] c);
    if (!letter_char(c)) begin
      halt_now();
    end else begin
      emit(K_NAME, c);
      phase = PH_NAME;
    end
  endfunction

  function automatic void within_line(input logic [BYTE_W-1:0] c);
    case (phase)
      PH_NAME: begin
        if (space_char(c)) phase = PH_NAME_SP;
        else if (c == CH_EQ) phase = PH_VAL_SP;
        else if (!word_char(c)) halt_now();
        else emit(K_NAME, c);
      end
      PH_NAME_SP: begin
        if (!space_char(c)) begin
          if (c == CH_EQ) phase = PH_VAL_SP;
          else halt_now();
        end
      end
      PH_VAL_SP: begin
        if (!space_char(c)) value_char(c);
      end
      PH_VAL: begin
        if (space_char(c)) begin
          if (held_sp < PENDING_MAX) held_sp++;
        end else begin
          value_char(c);
        end
      end
      default: halt_now();
    endcase
  endfunction

  function automatic void at_line_begin(input logic [BYTE_W-1:0] c);
    case (phase)
      PH_NAME: begin
        if (!space_char(c)) begin
          halt_now();
        end else begin
          phase = PH_NAME_SP;
          within_line(c);
        end
      end
      PH_NAME_SP: within_line(c);
      PH_VAL, PH_VAL_SP: begin
        // a line break inside a value stands for exactly one space
        if (phase == PH_VAL) begin
          held_sp = 1;
          phase   = PH_VAL_SP;
        end
        if (!space_char(c)) begin
          close_edit();
          start_name(c);
        end
      end
      default: start_name(c);
    endcase
  endfunction

  function automatic void blank_line();
    case (phase)
      PH_NAME, PH_NAME_SP: halt_now();
      PH_VAL, PH_VAL_SP:   close_edit();
      default: ;
    endcase
  endfunction

  function automatic void predict_step(input logic [BYTE_W-1:0] c, input logic eot);
    logic skip;
    skip    = 1'b0;
    n_step  = 0;
    err_hit = 1'b0;
    if (stopped) return;
    if (eot) begin
      blank_line();
      if (!err_hit) clear_state();
    end else begin
      if (c == CH_HASH) in_remark = 1'b1;
      // newlines count before anything else, in comments too
      if (c == CH_NL && line_no != LINE_MAX) line_no++;
      if (in_remark) begin
        if (c != CH_NL) begin
          skip = 1'b1;
        end else begin
          in_remark = 1'b0;
          at_bol    = 1'b0;
        end
      end
      if (!skip) begin
        if (c == CH_NL) begin
          if (at_bol) blank_line();
          at_bol = 1'b1;
        end else begin
          if (at_bol) at_line_begin(c);
          else within_line(c);
          at_bol = 1'b0;
        end
      end
    end
    if (n_step > 0) tokens_due[tokens_due.size()-1].last = 1'b1;
  endfunction

  function automatic void mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
    if (n_fail < 40) $error("%s: expected %0d, got %0d", field, want, got);
    n_fail++;
  endfunction

  function automatic void check_token();
    token_t t;
    if (tokens_due.size() == 0) begin
      if (n_fail < 40)
        $error("token with nothing expected: kind %0d byte %0d line %0d",
               out_ch.token_kind, out_ch.token_byte, out_ch.error_line);
      n_fail++;
      return;
    end
    t = tokens_due.pop_front();
    if (out_ch.token_kind !== t.kind) mismatch("token_kind", t.kind, out_ch.token_kind);
    if (out_ch.token_byte !== t.ch) mismatch("token_byte", t.ch, out_ch.token_byte);
    if (out_ch.error_line !== t.line) mismatch("error_line", t.line, out_ch.error_line);
    if (out_ch.last_of_run !== t.last) mismatch("last_of_run", t.last, out_ch.last_of_run);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      stopped = 1'b0;
      tokens_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_token();
      if (in_ch.valid && in_ch.ready) predict_step(in_ch.text_byte, in_ch.end_of_text);
    end
    n_pending = tokens_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the edit stream parser: clock, reset, text stimulus, sink and verdict
`timescale 1ns / 100ps
module tb_top;
  import easp_pkg::*;

  localparam int PEND_MAX    = 32;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        hold_off      = 1'b0;
  int          n_fail;
  int          n_pending;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned sent_cnt      = 0;
  int unsigned idle_plan [4] = '{0, 57, 0, 27};
  int unsigned stall_plan[4] = '{0, 0, 57, 27};

  easp_in_if  in_ch ();
  easp_out_if out_ch ();

  env_assignment_stream_parser_top #(.PENDING_MAX(PEND_MAX)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  easp_token_checker #(.PENDING_MAX(PEND_MAX)) tok_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .n_fail(n_fail), .n_pending(n_pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // token sink: random stalls, or one long freeze on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic send(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= c;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic put(input logic [7:0] c);
    send(c, 1'b0);
  endtask

  task automatic put_eot();
    send(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // whitespace other than newline, mostly plain spaces
  task automatic put_ws(input int lo, input int hi);
    logic [7:0] c;
    repeat ($urandom_range(hi, lo)) begin
      c = 8'($urandom_range(13, 9));
      if (c == CH_NL || chance(60)) c = CH_SP;
      put(c);
    end
  endtask

  task automatic put_name();
    int unsigned r;
    r = $urandom_range(52);
    put(r < 26 ? 8'(8'h41 + r) : r < 52 ? 8'(8'h61 + r - 26) : CH_UNDER);
    repeat ($urandom_range(5)) begin
      r = $urandom_range(62);
      put(r < 26 ? 8'(8'h41 + r) : r < 52 ? 8'(8'h61 + r - 26) :
          r < 62 ? 8'(8'h30 + r - 52) : CH_UNDER);
    end
  endtask

  task automatic put_val_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_SP || (c >= 8'd9 && c <= 8'd13) || c == CH_HASH);
    put(c);
  endtask

  // comment text up to, not including, the newline
  task automatic put_comment();
    logic [7:0] c;
    put(CH_HASH);
    repeat ($urandom_range(4)) begin
      do c = 8'($urandom_range(255));
      while (c == CH_NL);
      put(c);
    end
  endtask

  task automatic rand_edit();
    put_name();
    if (chance(15)) begin
      // name carried onto an indented line before the equals sign
      put(CH_NL);
      put_ws(1, 3);
    end else if (chance(50)) begin
      put_ws(1, 3);
    end
    put(CH_EQ);
    if (chance(50)) put_ws(1, 3);
    if (!chance(15)) begin
      repeat ($urandom_range(8, 1)) begin
        if (chance(20)) put_ws(1, 4);
        else put_val_char();
      end
      if (chance(8)) begin
        put_ws(33, 45);
        put_val_char();
      end
    end
    if (chance(30)) put_ws(1, 3);
    if (chance(25)) put_comment();
    put(CH_NL);
    if (chance(30)) begin
      put_ws(1, 3);
      repeat ($urandom_range(4, 1)) put_val_char();
      if (chance(25)) put_comment();
      put(CH_NL);
    end
    case ($urandom_range(9))
      0, 1, 2: put(CH_NL);
      3, 4:    put_eot();
      5: begin
        put_comment();
        put(CH_NL);
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk);
    while (n_pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int unsigned target;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte extremes, a comment line inside an edit, continuation, set and delete ends
    put_str("A_z9=");
    put(8'h00);
    put(8'hff);
    put(CH_NL);
    put(CH_HASH);
    put(8'h80);
    put(CH_NL);
    put(8'h09);
    put_str("~\n\n");
    put_str("b = ");
    put_eot();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = idle_plan[ph];
      snk_stall_pct = stall_plan[ph];
      if (ph == 0) begin
        // sink frozen while a value and a saturating space run go in
        hold_off <= 1'b1;
        put_str("fill=");
        repeat (8) put_val_char();
        put_ws(40, 40);
        put_val_char();
        put_str("\n\n");
        drain();
      end
      target = sent_cnt + 25;
      while (sent_cnt < target) begin
        if (chance(10)) begin
          if (chance(50)) put_comment();
          put(CH_NL);
        end else begin
          rand_edit();
        end
      end
      put_eot();
      drain();
    end

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    put_str("z=1\n\n");

    // one syntax error, after which the parser ignores everything
    case ($urandom_range(6))
      0: put(chance(50) ? 8'h37 : 8'($urandom_range(255, 128)));
      1: put_str("ab-");
      2: put_str("ab\n\n");
      3: begin
        put_str("ab");
        put_eot();
      end
      4: put_str("ab c");
      5: put_str("ab\nc");
      default: put_str("a=1\n9");
    endcase
    repeat (3) put(8'($urandom_range(255)));
    drain();

    repeat (16) @(negedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/easp_pkg.sv
rtl/easp_if.sv
rtl/easp_front.sv
rtl/easp_cmd_fifo.sv
rtl/easp_back.sv
rtl/env_assignment_stream_parser_top.sv
tb/easp_token_checker.sv
tb/tb_top.sv
